[src/rty_pkg.sv]
// constants, types and arithmetic helpers shared by the rgb to yuv pixel writer
package rty_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgLineWidth  = 2'd0,
    CfgPackMode   = 2'd1,
    CfgBufferBase = 2'd2
  } cfg_reg_e;

  // packing phase of a 4:1:1 word
  typedef enum logic [1:0] {
    PhaseVyyy = 2'd0,
    PhaseUyvy = 2'd1,
    PhaseYyuy = 2'd2
  } phase_e;

  localparam logic [9:0]  LineWidthReset  = 10'd720;
  localparam logic        PackModeReset   = 1'b0;
  localparam logic [31:0] BufferBaseReset = 32'h4480_0000;

  localparam logic PackMode422 = 1'b0;
  localparam logic PackMode411 = 1'b1;

  localparam int IdxW = 21;   // pixel index, up to 1023 * 1023 + 1023
  localparam int OffW = 22;   // byte offset into the buffer
  localparam int SumW = 20;   // signed weighted colour sum

  localparam logic signed [11:0] KYR = 12'sd217;
  localparam logic signed [11:0] KYG = 12'sd732;
  localparam logic signed [11:0] KYB = 12'sd73;
  localparam logic signed [11:0] KUR = -12'sd117;
  localparam logic signed [11:0] KUG = -12'sd394;
  localparam logic signed [11:0] KUB = 12'sd512;
  localparam logic signed [11:0] KVR = 12'sd512;
  localparam logic signed [11:0] KVG = -12'sd465;
  localparam logic signed [11:0] KVB = -12'sd46;

  localparam logic signed [9:0] LumaMin   = 10'sd0;
  localparam logic signed [9:0] LumaMax   = 10'sd255;
  localparam logic signed [9:0] ChromaMin = -10'sd128;
  localparam logic signed [9:0] ChromaMax = 10'sd127;

  localparam logic signed [SumW-1:0] RoundBias = 20'sd1023;

  function automatic logic signed [SumW-1:0] wsum(
    logic [7:0] r, logic [7:0] g, logic [7:0] b,
    logic signed [11:0] kr, logic signed [11:0] kg, logic signed [11:0] kb
  );
    logic signed [SumW-1:0] sr, sg, sb;
    sr = $signed({12'b0, r});
    sg = $signed({12'b0, g});
    sb = $signed({12'b0, b});
    return sr * SumW'(kr) + sg * SumW'(kg) + sb * SumW'(kb);
  endfunction

  // divide by 1024 truncating toward zero, then clamp to lo..hi
  function automatic logic [7:0] scale_clamp(
    logic signed [SumW-1:0] s, logic signed [9:0] lo, logic signed [9:0] hi
  );
    logic signed [SumW-1:0] t;
    logic signed [9:0]      q;
    logic signed [9:0]      c;
    t = (s < 0) ? s + RoundBias : s;
    q = t[SumW-1:10];
    if (q < lo) begin
      c = lo;
    end else if (q > hi) begin
      c = hi;
    end else begin
      c = q;
    end
    return c[7:0];
  endfunction

  // word index mod 3, from base-4 digits since 4 is 1 mod 3
  function automatic phase_e word_phase(logic [29:0] w);
    logic [3:0] grp [5];
    logic [5:0] acc;
    logic [3:0] fold;
    phase_e     ph;
    for (int i = 0; i < 5; i++) begin
      grp[i] = 4'(w[6*i +: 2]) + 4'(w[6*i+2 +: 2]) + 4'(w[6*i+4 +: 2]);
    end
    acc = 6'(grp[0]) + 6'(grp[1]) + 6'(grp[2]) + 6'(grp[3]) + 6'(grp[4]);
    fold = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]);
    if (fold inside {4'd0, 4'd3, 4'd6, 4'd9}) begin
      ph = PhaseVyyy;
    end else if (fold inside {4'd1, 4'd4, 4'd7}) begin
      ph = PhaseUyvy;
    end else begin
      ph = PhaseYyuy;
    end
    return ph;
  endfunction

endpackage

[src/rty_pix_if.sv]
// pixel input channel
interface rty_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

[src/rty_res_if.sv]
// result channel: store address and packed word
interface rty_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;
  logic [31:0] packed_word;

  modport source (output valid, byte_address, packed_word, input ready);
  modport sink   (input valid, byte_address, packed_word, output ready);
endinterface

[src/rty_cfg_if.sv]
// configuration write channel
interface rty_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/rgb_to_yuv_pixel_writer_top.sv]
// rgb to yuv pixel writer: three-stage pipeline from pixel to frame buffer store
//
//  channel  dir  handshake     word
//  pix_i    in   valid/ready   pixel_x, pixel_y, red, green, blue
//  res_o    out  valid/ready   byte_address, packed_word
//  cfg_i    in   valid/ready   index, data (ready always high)
//
// one pixel per clock sustained while res_o is ready; each result passes the stage 1, 2 and 3 registers
// stage 1: pixel index multiply and colour weighted sums
// stage 2: buffer offset and base add, divide and clamp of y, u, v
// stage 3 (output register): 4:1:1 phase from word address mod 3 and byte packing
// reset brings configuration registers to their defaults and empties the pipe
// a stall at the output holds each full stage; empty stages still fill
module rgb_to_yuv_pixel_writer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  rty_pix_if.sink   pix_i,
  rty_res_if.source res_o,
  rty_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [9:0]  line_width_q;
  logic        pack_mode_q;
  logic [31:0] buffer_base_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q  <= rty_pkg::LineWidthReset;
      pack_mode_q   <= rty_pkg::PackModeReset;
      buffer_base_q <= rty_pkg::BufferBaseReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rty_pkg::CfgLineWidth:  line_width_q  <= cfg_i.data[9:0];
        rty_pkg::CfgPackMode:   pack_mode_q   <= cfg_i.data[0];
        rty_pkg::CfgBufferBase: buffer_base_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic vld1_q, vld2_q, vld3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !vld3_q || res_o.ready;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;
  assign pix_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        vld1_q <= pix_i.valid;
      end
      if (rdy2) begin
        vld2_q <= vld1_q;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
    end
  end

  // stage 1
  logic [rty_pkg::IdxW-1:0]        idx1_d, idx1_q;
  logic signed [rty_pkg::SumW-1:0] ysum1_d, usum1_d, vsum1_d;
  logic signed [rty_pkg::SumW-1:0] ysum1_q, usum1_q, vsum1_q;
  logic                            mode1_q;

  always_comb begin
    idx1_d = rty_pkg::IdxW'(pix_i.pixel_y) * rty_pkg::IdxW'(line_width_q)
           + rty_pkg::IdxW'(pix_i.pixel_x);
    ysum1_d = rty_pkg::wsum(pix_i.red, pix_i.green, pix_i.blue,
                            rty_pkg::KYR, rty_pkg::KYG, rty_pkg::KYB);
    usum1_d = rty_pkg::wsum(pix_i.red, pix_i.green, pix_i.blue,
                            rty_pkg::KUR, rty_pkg::KUG, rty_pkg::KUB);
    vsum1_d = rty_pkg::wsum(pix_i.red, pix_i.green, pix_i.blue,
                            rty_pkg::KVR, rty_pkg::KVG, rty_pkg::KVB);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      idx1_q  <= idx1_d;
      ysum1_q <= ysum1_d;
      usum1_q <= usum1_d;
      vsum1_q <= vsum1_d;
      mode1_q <= pack_mode_q;
    end
  end

  // stage 2
  logic [rty_pkg::OffW-1:0] off2;
  logic [31:0]              addr2_d, addr2_q;
  logic [7:0]               luma2_q, cb2_q, cr2_q;
  logic                     mode2_q;

  always_comb begin
    // 4:1:1 offset is index * 12 / 8, that is index + index / 2
    if (mode1_q == rty_pkg::PackMode411) begin
      off2 = rty_pkg::OffW'(idx1_q) + rty_pkg::OffW'(idx1_q[rty_pkg::IdxW-1:1]);
    end else begin
      off2 = {idx1_q, 1'b0};
    end
    addr2_d = buffer_base_q + 32'(off2);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && vld1_q) begin
      addr2_q <= addr2_d;
      luma2_q <= rty_pkg::scale_clamp(ysum1_q, rty_pkg::LumaMin, rty_pkg::LumaMax);
      cb2_q   <= rty_pkg::scale_clamp(usum1_q, rty_pkg::ChromaMin, rty_pkg::ChromaMax);
      cr2_q   <= rty_pkg::scale_clamp(vsum1_q, rty_pkg::ChromaMin, rty_pkg::ChromaMax);
      mode2_q <= mode1_q;
    end
  end

  // stage 3
  rty_pkg::phase_e phase3;
  logic [31:0]     word3_d, word3_q, addr3_q;

  always_comb begin
    phase3 = rty_pkg::word_phase(addr2_q[31:2]);
    if (mode2_q == rty_pkg::PackMode422) begin
      word3_d = {luma2_q, cr2_q, luma2_q, cb2_q};
    end else begin
      case (phase3)
        rty_pkg::PhaseVyyy: word3_d = {luma2_q, luma2_q, luma2_q, cr2_q};
        rty_pkg::PhaseUyvy: word3_d = {luma2_q, cr2_q, luma2_q, cb2_q};
        default:            word3_d = {luma2_q, cb2_q, luma2_q, luma2_q};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && vld2_q) begin
      addr3_q <= addr2_q;
      word3_q <= word3_d;
    end
  end

  assign res_o.valid        = vld3_q;
  assign res_o.byte_address = addr3_q;
  assign res_o.packed_word  = word3_q;

  // byte 1 and byte 3 carry luma in every packing
  a_luma_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> word3_q[15:8] == word3_q[31:24])
    else $error("luma bytes of result word differ");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q && !rdy2 |=> vld1_q)
    else $error("stage 1 word dropped during stall");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld3_q |-> pix_i.ready)
    else $error("input stalled with empty output stage");

endmodule
